// ===== rtl/ups_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// ups_seq_pkg
// Shared types and constants of the UPS power sequencer.
// ----------------------------------------------------------------------------
package ups_seq_pkg;

   // field widths
   localparam int VOLT_W   = 8;
   localparam int COUNT_W  = 8;
   localparam int STATE_W  = 3;
   localparam int ACTION_W = 2;
   localparam int DELAY_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 8;

   // parameter defaults
   localparam int SHUTDOWN_DELAY_TICKS_DEF = 10;
   localparam int COUNTDOWN_DIVIDE_DEF     = 10;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_THRESHOLD     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ON_THRESHOLD      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POWERUP_THRESHOLD = 2'd2;

   // sequencer states, same codes as the reported state
   typedef enum logic [STATE_W-1:0] {
      ST_DISABLED      = 3'd0,
      ST_WAIT_OFF      = 3'd1,
      ST_WAIT_ON       = 3'd2,
      ST_POWERUP       = 3'd3,
      ST_RUNNING       = 3'd4,
      ST_FAIL_DELAY    = 3'd5,
      ST_CYCLE_DELAY   = 3'd6,
      ST_FAIL_SHUTDOWN = 3'd7
   } state_type;

   // request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_FORCE = 2'd2
   } action_type;

endpackage

// ===== rtl/ups_seq_if.sv =====
// ----------------------------------------------------------------------------
// ups_seq_if
// Valid/ready channels of the UPS power sequencer: request, response, csr.
// ----------------------------------------------------------------------------

// request channel
interface ups_seq_req_if;
   logic                                valid;
   logic                                ready;
   logic [ups_seq_pkg::ACTION_W-1:0]    action;
   logic [ups_seq_pkg::VOLT_W-1:0]      input_voltage;
   logic [ups_seq_pkg::VOLT_W-1:0]      backup_voltage;
   logic [ups_seq_pkg::COUNT_W-1:0]     countdown_value;
   logic [ups_seq_pkg::STATE_W-1:0]     forced_state;

   modport source (output valid, action, input_voltage, backup_voltage,
                   countdown_value, forced_state, input ready);
   modport sink   (input valid, action, input_voltage, backup_voltage,
                   countdown_value, forced_state, output ready);
endinterface

// response channel
interface ups_seq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ups_seq_pkg::STATE_W-1:0]     state_code;
   logic                                output_enable;
   logic [ups_seq_pkg::COUNT_W-1:0]     countdown_left;

   modport source (output valid, state_code, output_enable, countdown_left,
                   input ready);
   modport sink   (input valid, state_code, output_enable, countdown_left,
                   output ready);
endinterface

// configuration write channel
interface ups_seq_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ups_seq_pkg::CSR_IDX_W-1:0]   index;
   logic [ups_seq_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/ups_power_sequencer.sv =====
// ----------------------------------------------------------------------------
// ups_power_sequencer
// Switches a load output from sampled input and backup supply levels.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one beat per tick with samples, countdown load or state
//   force. Every request beat yields exactly one rsp_bus beat with the state
//   code, output enable and remaining countdown after that request.
//   csr_bus writes the off, on and powerup thresholds (index 0, 1, 2);
//   index 3 is accepted and ignored. csr_ready is always high.
// Throughput:
//   the response is held in registers. One request per cycle is taken while
//   rsp_bus is not stalled; the sequencer state registers double as the
//   response register, so a new beat is taken in the same cycle the pending
//   response is consumed.
// Stall:
//   while rsp_bus is stalled the response holds and req_ready stays low.
// Reset:
//   thresholds go to zero, state to powerup, output off, countdown and
//   delay counters to zero; no response is pending.
// ----------------------------------------------------------------------------
module ups_power_sequencer #(
   parameter int SHUTDOWN_DELAY_TICKS = ups_seq_pkg::SHUTDOWN_DELAY_TICKS_DEF,
   parameter int COUNTDOWN_DIVIDE     = ups_seq_pkg::COUNTDOWN_DIVIDE_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   ups_seq_req_if.sink          req_bus,
   ups_seq_rsp_if.source        rsp_bus,
   ups_seq_csr_if.sink          csr_bus
);

   localparam logic [ups_seq_pkg::DELAY_W-1:0] DELAY_LOAD =
      ups_seq_pkg::DELAY_W'(SHUTDOWN_DELAY_TICKS);
   localparam logic [ups_seq_pkg::DELAY_W:0] PHASE_WRAP =
      (ups_seq_pkg::DELAY_W + 1)'(COUNTDOWN_DIVIDE);

   // thresholds
   logic [ups_seq_pkg::VOLT_W-1:0]  off_thr_ff;
   logic [ups_seq_pkg::VOLT_W-1:0]  on_thr_ff;
   logic [ups_seq_pkg::VOLT_W-1:0]  pwr_thr_ff;

   // sequencer state, also the response payload
   ups_seq_pkg::state_type          state_ff, state_in;
   logic                            enable_ff, enable_in;
   logic [ups_seq_pkg::COUNT_W-1:0] countdown_ff, countdown_in;
   logic [ups_seq_pkg::DELAY_W-1:0] fail_cnt_ff, fail_cnt_in;
   logic [ups_seq_pkg::DELAY_W-1:0] cycle_cnt_ff, cycle_cnt_in;
   logic [ups_seq_pkg::DELAY_W-1:0] phase_ff, phase_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic                            req_fire;
   logic                            in_low;
   logic                            in_high;
   logic                            bk_low;
   logic                            bk_ready;
   logic [ups_seq_pkg::DELAY_W:0]   phase_inc;
   logic [ups_seq_pkg::COUNT_W-1:0] countdown_dec;
   logic [ups_seq_pkg::DELAY_W-1:0] fail_dec;
   logic [ups_seq_pkg::DELAY_W-1:0] cycle_dec;

   // handshakes
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         off_thr_ff <= '0;
         on_thr_ff  <= '0;
         pwr_thr_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            ups_seq_pkg::CSR_OFF_THRESHOLD:     off_thr_ff <= csr_bus.data;
            ups_seq_pkg::CSR_ON_THRESHOLD:      on_thr_ff  <= csr_bus.data;
            ups_seq_pkg::CSR_POWERUP_THRESHOLD: pwr_thr_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // level compares
   assign in_low   = req_bus.input_voltage <= off_thr_ff;
   assign in_high  = req_bus.input_voltage >= on_thr_ff;
   assign bk_low   = req_bus.backup_voltage <= off_thr_ff;
   assign bk_ready = req_bus.backup_voltage >= pwr_thr_ff;

   // tick arithmetic
   assign phase_inc = {1'b0, phase_ff} + 1'b1;
   assign countdown_dec = (phase_ff == '0) ? countdown_ff - 1'b1 : countdown_ff;
   assign fail_dec  = (fail_cnt_ff != '0) ? fail_cnt_ff - 1'b1 : fail_cnt_ff;
   assign cycle_dec = (cycle_cnt_ff != '0) ? cycle_cnt_ff - 1'b1 : cycle_cnt_ff;

   // next state of the sequencer
   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      countdown_in = countdown_ff;
      fail_cnt_in  = fail_cnt_ff;
      cycle_cnt_in = cycle_cnt_ff;
      phase_in     = phase_ff;
      unique case (ups_seq_pkg::action_type'(req_bus.action))
         ups_seq_pkg::ACT_TICK: begin
            unique case (state_ff)
               ups_seq_pkg::ST_WAIT_OFF: begin
                  if (in_low) state_in = ups_seq_pkg::ST_WAIT_ON;
               end
               ups_seq_pkg::ST_WAIT_ON: begin
                  if (in_high) state_in = ups_seq_pkg::ST_POWERUP;
               end
               ups_seq_pkg::ST_POWERUP, ups_seq_pkg::ST_FAIL_SHUTDOWN: begin
                  if (in_high && bk_ready) begin
                     countdown_in = '0;
                     enable_in    = 1'b1;
                     state_in     = ups_seq_pkg::ST_RUNNING;
                  end
               end
               ups_seq_pkg::ST_RUNNING: begin
                  // supply failure first, countdown expiry may override
                  if (in_low && bk_low) begin
                     enable_in   = 1'b0;
                     fail_cnt_in = DELAY_LOAD;
                     state_in    = ups_seq_pkg::ST_FAIL_DELAY;
                  end
                  if (countdown_ff != '0) begin
                     countdown_in = countdown_dec;
                     if (countdown_dec == '0) begin
                        cycle_cnt_in = DELAY_LOAD;
                        state_in     = ups_seq_pkg::ST_CYCLE_DELAY;
                        enable_in    = 1'b0;
                     end
                  end
               end
               ups_seq_pkg::ST_FAIL_DELAY: begin
                  fail_cnt_in = fail_dec;
                  if (fail_dec == '0) state_in = ups_seq_pkg::ST_FAIL_SHUTDOWN;
               end
               ups_seq_pkg::ST_CYCLE_DELAY: begin
                  cycle_cnt_in = cycle_dec;
                  if (cycle_dec == '0) state_in = ups_seq_pkg::ST_WAIT_OFF;
               end
               default: ;
            endcase
            // tick phase wraps at the countdown divide
            phase_in = (phase_inc >= PHASE_WRAP) ? '0 : phase_inc[ups_seq_pkg::DELAY_W-1:0];
         end
         ups_seq_pkg::ACT_LOAD: begin
            countdown_in = req_bus.countdown_value;
         end
         ups_seq_pkg::ACT_FORCE: begin
            state_in  = ups_seq_pkg::state_type'(req_bus.forced_state);
            enable_in = (req_bus.forced_state == ups_seq_pkg::ST_RUNNING);
         end
         default: ;
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire)          rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   // state registers, updated on each request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ups_seq_pkg::ST_POWERUP;
         enable_ff    <= 1'b0;
         countdown_ff <= '0;
         fail_cnt_ff  <= '0;
         cycle_cnt_ff <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            state_ff     <= state_in;
            enable_ff    <= enable_in;
            countdown_ff <= countdown_in;
            fail_cnt_ff  <= fail_cnt_in;
            cycle_cnt_ff <= cycle_cnt_in;
            phase_ff     <= phase_in;
         end
      end
   end

   // response beat
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.state_code     = state_ff;
   assign rsp_bus.output_enable  = enable_ff;
   assign rsp_bus.countdown_left = countdown_ff;

endmodule

// ===== rtl/ups_seq_checker.sv =====
// ----------------------------------------------------------------------------
// ups_seq_checker
// Port-level checks of the UPS power sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ups_seq_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [ups_seq_pkg::ACTION_W-1:0]    req_action,
   input  logic [ups_seq_pkg::COUNT_W-1:0]     req_countdown_value,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [ups_seq_pkg::STATE_W-1:0]     rsp_state_code,
   input  logic                                rsp_output_enable,
   input  logic [ups_seq_pkg::COUNT_W-1:0]     rsp_countdown_left
);

   // no response pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // every request beat gives a response in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request beat without response");

   // output enable follows the running state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_output_enable == (rsp_state_code == ups_seq_pkg::ST_RUNNING)))
      else $error("output enable does not match running state");

   // a countdown load is reported back as written
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ups_seq_pkg::ACT_LOAD)
      |=> rsp_countdown_left == $past(req_countdown_value))
      else $error("countdown load not reported");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_state_code)
         && $stable(rsp_output_enable) && $stable(rsp_countdown_left))
      else $error("stalled response changed");

endmodule

bind ups_power_sequencer ups_seq_checker u_ups_seq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_bus.valid),
   .req_ready           (req_bus.ready),
   .req_action          (req_bus.action),
   .req_countdown_value (req_bus.countdown_value),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .rsp_state_code      (rsp_bus.state_code),
   .rsp_output_enable   (rsp_bus.output_enable),
   .rsp_countdown_left  (rsp_bus.countdown_left)
);
